// ===== sv/fps_pkg.sv =====
// Shared constants and types for the prefix sum table.
// Depends on nothing; the top level refers to it by scoped names.
package fps_pkg;

    localparam int DEPTH   = 16384;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int K_W     = ADDR_W + 2;
    localparam int IDX_W   = 14;
    localparam int DELTA_W = 32;
    localparam int NODE_W  = 48;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [K_W-1:0]    t_k;
    typedef logic [ADDR_W-1:0] t_addr;

endpackage

// ===== sv/fps_ram.sv =====
// Generic single write, single read RAM with a registered read port.
// Stands alone; width and depth come in as parameters.
module fps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/fenwick_prefix_sum_table.sv =====
// Top level of the binary indexed prefix sum table: sequencer, node walk, result register.
// Depends on fps_pkg and on fps_ram, which holds the tree nodes.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_mode, i_slot_index, i_delta
//   result   out        o_valid / i_stall      o_prefix_total
//
// After reset the node store is cleared one node a cycle, with o_stall high. An add
// passes through S_READ and S_WALK, a query through S_READ, S_WALK and S_DONE up to the
// result register; the walk visits at most log2(DEPTH)+1 = 15 nodes, and the single
// memory port pair reads one node and writes one node per cycle.
// An add beyond the table is taken and does nothing.
// A waiting result does not block the next transfer; only a second result waits for it.
module fenwick_prefix_sum_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [13:0] i_slot_index,
    input  logic [31:0] i_delta,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_prefix_total
);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]     r_state, n_state;
    fps_pkg::t_addr r_clr, n_clr;
    fps_pkg::t_k    r_k, n_k;
    logic           r_mode, n_mode;
    fps_pkg::t_node r_amt, n_amt;
    fps_pkg::t_node r_acc, n_acc;
    logic           r_out_valid, n_out_valid;
    fps_pkg::t_node r_out_data, n_out_data;

    // RAM ports
    logic           w_wr_en;
    fps_pkg::t_addr w_wr_addr;
    fps_pkg::t_node w_wr_data;
    fps_pkg::t_addr w_rd_addr;
    fps_pkg::t_node w_rd_data;

    // Node walk arithmetic
    fps_pkg::t_k    w_low;
    fps_pkg::t_k    w_k_up;
    fps_pkg::t_k    w_k_dn;
    logic [31:0]    w_slot;
    logic           w_in_range;
    logic [31:0]    w_slot_sat;
    fps_pkg::t_k    w_k0;
    fps_pkg::t_node w_delta_ext;

    fps_ram #(
        .WIDTH (fps_pkg::NODE_W),
        .DEPTH (fps_pkg::DEPTH)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Lowest set bit of the current node number drives both walk directions.
    assign w_low  = r_k & (~r_k + fps_pkg::t_k'(1));
    assign w_k_up = r_k + w_low;
    assign w_k_dn = r_k - w_low;

    // Slot range check and saturation for queries beyond the table.
    assign w_slot      = 32'(i_slot_index);
    assign w_in_range  = w_slot < 32'(fps_pkg::DEPTH);
    assign w_slot_sat  = w_in_range ? w_slot : 32'(fps_pkg::DEPTH - 1);
    assign w_k0        = fps_pkg::t_k'(w_slot_sat + 32'd1);
    assign w_delta_ext = {{(fps_pkg::NODE_W - fps_pkg::DELTA_W){i_delta[fps_pkg::DELTA_W-1]}},
                          i_delta};

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_prefix_total = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_k         = r_k;
        n_mode      = r_mode;
        n_amt       = r_amt;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_wr_en     = 1'b0;
        w_wr_addr   = fps_pkg::t_addr'(r_k - fps_pkg::t_k'(1));
        w_wr_data   = w_rd_data + r_amt;
        w_rd_addr   = fps_pkg::t_addr'(r_k - fps_pkg::t_k'(1));

        // Drop the result once it has been transferred.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep zeros through the node store.
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = '0;
                n_clr     = r_clr + fps_pkg::t_addr'(1);
                if (r_clr == fps_pkg::t_addr'(fps_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_amt  = w_delta_ext;
                    n_acc  = '0;
                    n_k    = w_k0;
                    // An add beyond the table is taken and dropped.
                    if (i_mode == fps_pkg::MODE_QUERY || w_in_range) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // Issue the read of the first node; data lands next cycle.
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_mode == fps_pkg::MODE_ADD) begin
                    // Write back node k and fetch the next node up in the same cycle.
                    w_wr_en   = 1'b1;
                    w_rd_addr = fps_pkg::t_addr'(w_k_up - fps_pkg::t_k'(1));
                    n_k       = w_k_up;
                    if (w_k_up > fps_pkg::t_k'(fps_pkg::DEPTH)) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    // Accumulate node k and fetch the next node down.
                    n_acc     = r_acc + w_rd_data;
                    w_rd_addr = fps_pkg::t_addr'(w_k_dn - fps_pkg::t_k'(1));
                    n_k       = w_k_dn;
                    if (w_k_dn == '0) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Hold the sum until the result register is free.
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_mode     <= n_mode;
        r_amt      <= n_amt;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

`ifndef ASSERT_OFF
    // The node under the walk always lies inside the table.
    a_node_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_k != '0 && r_k <= fps_pkg::t_k'(fps_pkg::DEPTH)))
        else $error("node walk left the table");

    // A finished query reaches the result register on leaving S_DONE.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || !i_stall)) |=> (o_valid && r_state == S_IDLE))
        else $error("finished query did not load the result register");

    // A result is only dropped by a transfer.
    a_drop_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && r_state != S_DONE) |=> o_valid)
        else $error("result lost while stalled");
`endif

endmodule
